[rtl/core/bstf_pkg.sv]
package bstf_pkg;

  // Tile RAM geometry: four pages of 4096 bytes, held as two byte banks
  // (even and odd byte addresses) so that a code and attribute pair reads at once.
  localparam int PAGE_BYTES  = 4096;
  localparam int PAGES       = 4;
  localparam int RAM_BYTES   = PAGE_BYTES * PAGES;
  localparam int BYTE_ADDR_W = $clog2(RAM_BYTES);
  localparam int WORD_ADDR_W = BYTE_ADDR_W - 1;
  localparam int OFFSET_W    = $clog2(PAGE_BYTES);
  localparam int PAGE_W      = $clog2(PAGES);

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_X    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_Y    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDE_LAYOUT = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BG_ENABLE   = 2'd3;

  // Command codes.
  localparam logic [1:0] ACT_RAM_WRITE = 2'd0;
  localparam logic [1:0] ACT_RAM_READ  = 2'd1;
  localparam logic [1:0] ACT_PAGE_SEL  = 2'd2;
  localparam logic [1:0] ACT_FETCH     = 2'd3;

  typedef struct packed {
    logic [1:0]          action;
    logic [OFFSET_W-1:0] cpu_offset;
    logic [7:0]          write_data;
    logic [4:0]          screen_col;
    logic [4:0]          screen_row;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [10:0] tile_code;
    logic [3:0]  tile_colour;
    logic        tile_flip_x;
    logic [6:0]  map_col;
    logic [6:0]  map_row;
    logic        tile_valid;
  } result_t;

  // Location of one tile entry in the map, as found by the address generator.
  typedef struct packed {
    logic [WORD_ADDR_W-1:0] word_addr;
    logic [6:0]             map_col;
    logic [6:0]             map_row;
  } tile_loc_t;

endpackage

[rtl/core/bstf_bank_ram.sv]
module bstf_bank_ram #(
  parameter int ADDR_W = 13,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Single port, read data registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/core/bstf_addr_gen.sv]
module bstf_addr_gen (
  input  logic [15:0]       scroll_x,
  input  logic [15:0]       scroll_y,
  input  logic              wide_layout,
  input  logic [4:0]        screen_col,
  input  logic [4:0]        screen_row,
  output bstf_pkg::tile_loc_t loc
);

  logic [6:0] cx;
  logic [6:0] cy;
  logic [6:0] x;
  logic [6:0] y;

  // Coarse scroll added to the screen position; only the low seven bits survive the wrap.
  assign cx = scroll_x[10:4] + {2'b00, screen_col};
  assign cy = scroll_y[10:4] + {2'b00, screen_row};

  // Wrap to 128x64 tiles in the wide layout, 64x128 tiles otherwise, and place the
  // two-byte entry: pages of 16x16 tiles, 32 bytes a tile row inside a page.
  always_comb begin
    if (wide_layout) begin
      x = cx;
      y = {1'b0, cy[5:0]};
      loc.word_addr = {y[5:4], x[6:4], y[3:0], x[3:0]};
    end else begin
      x = {1'b0, cx[5:0]};
      y = cy;
      loc.word_addr = {y[6:4], x[5:4], y[3:0], x[3:0]};
    end
    loc.map_col = x;
    loc.map_row = y;
  end

endmodule

[rtl/core/banked_scroll_tilemap_fetch.sv]
// Channel        Signals                      Transaction
// command        start, busy, cmd             start high while busy is low
// result         done, result                 done high for one cycle
// configuration  cfg_we, cfg_index, cfg_data  cfg_we high at a clock edge
//
// A command is taken in the cycle that start is high and busy low, and its result appears in the next
// cycle, so one command per clock is sustained once the clearing pass is over; the single tile RAM access per
// command, through the registered read of the two byte banks, allows that rate.
// After reset the tile RAM is cleared one word a cycle, through every word of both banks, with busy
// high; configuration writes are taken during that time. The receiver cannot stall.
module banked_scroll_tilemap_fetch (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  bstf_pkg::cmd_t                     cmd,
  output logic                               done,
  output bstf_pkg::result_t                  result,
  input  logic                               cfg_we,
  input  logic [bstf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bstf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [15:0] scroll_x;
  logic [15:0] scroll_y;
  logic        wide_layout;
  logic        bg_enable;
  logic [bstf_pkg::PAGE_W-1:0] page_select;

  logic                                clearing;
  logic [bstf_pkg::WORD_ADDR_W-1:0]    clr_count;

  logic                                accept;
  logic [bstf_pkg::BYTE_ADDR_W-1:0]    cpu_addr;
  bstf_pkg::tile_loc_t                 loc;
  logic [bstf_pkg::WORD_ADDR_W-1:0]    ram_addr;
  logic [7:0]                          ram_wdata;
  logic                                we_even;
  logic                                we_odd;
  logic [7:0]                          rd_even;
  logic [7:0]                          rd_odd;

  logic [1:0]  action_q;
  logic        bank_q;
  logic [6:0]  map_col_q;
  logic [6:0]  map_row_q;
  logic        bg_q;

  assign busy   = clearing;
  assign accept = start && !busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_x    <= '0;
      scroll_y    <= '0;
      wide_layout <= 1'b0;
      bg_enable   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        bstf_pkg::REG_SCROLL_X:    scroll_x    <= cfg_data;
        bstf_pkg::REG_SCROLL_Y:    scroll_y    <= cfg_data;
        bstf_pkg::REG_WIDE_LAYOUT: wide_layout <= cfg_data[0];
        bstf_pkg::REG_BG_ENABLE:   bg_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Page register for the CPU window.
  always_ff @(posedge clk) begin
    if (rst) begin
      page_select <= '0;
    end else if (accept && cmd.action == bstf_pkg::ACT_PAGE_SEL) begin
      page_select <= cmd.write_data[bstf_pkg::PAGE_W-1:0];
    end
  end

  // Clearing pass over both banks after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_count <= '0;
    end else if (clearing) begin
      clr_count <= clr_count + 1'b1;
      if (&clr_count) begin
        clearing <= 1'b0;
      end
    end
  end

  // Tile entry location for a fetch.
  bstf_addr_gen u_addr_gen (
    .scroll_x    (scroll_x),
    .scroll_y    (scroll_y),
    .wide_layout (wide_layout),
    .screen_col  (cmd.screen_col),
    .screen_row  (cmd.screen_row),
    .loc         (loc)
  );

  // RAM port selection: clearing pass, tile fetch or CPU byte access.
  assign cpu_addr = {page_select, cmd.cpu_offset};

  always_comb begin
    if (clearing) begin
      ram_addr  = clr_count;
      ram_wdata = '0;
      we_even   = 1'b1;
      we_odd    = 1'b1;
    end else begin
      if (cmd.action == bstf_pkg::ACT_FETCH) begin
        ram_addr = loc.word_addr;
      end else begin
        ram_addr = cpu_addr[bstf_pkg::BYTE_ADDR_W-1:1];
      end
      ram_wdata = cmd.write_data;
      we_even   = accept && cmd.action == bstf_pkg::ACT_RAM_WRITE && !cpu_addr[0];
      we_odd    = accept && cmd.action == bstf_pkg::ACT_RAM_WRITE && cpu_addr[0];
    end
  end

  bstf_bank_ram #(
    .ADDR_W (bstf_pkg::WORD_ADDR_W),
    .DATA_W (8)
  ) u_ram_even (
    .clk   (clk),
    .we    (we_even),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (rd_even)
  );

  bstf_bank_ram #(
    .ADDR_W (bstf_pkg::WORD_ADDR_W),
    .DATA_W (8)
  ) u_ram_odd (
    .clk   (clk),
    .we    (we_odd),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (rd_odd)
  );

  // Result strobe is registered and follows the accepted command in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  // Command details kept alongside the RAM read.
  always_ff @(posedge clk) begin
    if (accept) begin
      action_q  <= cmd.action;
      bank_q    <= cpu_addr[0];
      map_col_q <= loc.map_col;
      map_row_q <= loc.map_row;
      bg_q      <= bg_enable;
    end
  end

  // Decode the read data into the result transaction.
  always_comb begin
    result = '0;
    case (action_q)
      bstf_pkg::ACT_RAM_READ: begin
        result.read_data = bank_q ? rd_odd : rd_even;
      end
      bstf_pkg::ACT_FETCH: begin
        result.tile_code   = {rd_odd[2:0], rd_even};
        result.tile_colour = rd_odd[6:3];
        result.tile_flip_x = rd_odd[7];
        result.map_col     = map_col_q;
        result.map_row     = map_row_q;
        result.tile_valid  = bg_q;
      end
      default: ;
    endcase
  end

  // A result only ever follows an accepted command.
  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result strobe without an accepted command");

  // No result is produced while the clearing pass runs.
  a_no_done_while_clearing: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("result strobe during the clearing pass");

  // A valid tile only comes from a fetch command.
  a_valid_from_fetch: assert property (@(posedge clk) disable iff (rst)
    (done && result.tile_valid) |-> $past(cmd.action == bstf_pkg::ACT_FETCH))
    else $error("tile marked valid for a command that is not a fetch");

endmodule

[sim/banked_scroll_tilemap_fetch_tb.sv]
module banked_scroll_tilemap_fetch_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 200000;
  localparam int PHASE_ITEMS  = 212;
  localparam int PHASES       = 8;

  typedef struct packed {
    bstf_pkg::cmd_t    c;
    logic              lit;
    bstf_pkg::result_t r;
  } step_t;

  logic                             clk       = 1'b0;
  logic                             rst       = 1'b1;
  logic                             start     = 1'b0;
  bstf_pkg::cmd_t                   cmd       = '0;
  logic                             cfg_we    = 1'b0;
  logic [bstf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [bstf_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                             busy;
  logic                             done;
  bstf_pkg::result_t                result;

  // Own copy of the block's state and registers.
  logic [7:0]  bg_ram [0:bstf_pkg::RAM_BYTES-1] = '{default: 8'h00};
  logic [1:0]  cpu_page    = 2'd0;
  logic [15:0] scroll_x_px = 16'd0;
  logic [15:0] scroll_y_px = 16'd0;
  logic        layout_wide = 1'b0;
  logic        layer_on    = 1'b1;

  // Outcome of the command currently offered; moves with cmd.
  bstf_pkg::result_t staged_outcome = '0;
  bstf_pkg::result_t outcomes_due [$];
  step_t             directed [$];

  int failures = 0;
  int results_checked = 0;
  int n_fetch = 0;
  int n_read = 0;
  int n_write = 0;
  int n_page = 0;
  int cycles = 0;
  int gap_max = 5;

  banked_scroll_tilemap_fetch uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Wrap the scrolled tile position to the map and find its two-byte entry.
  function automatic int map_entry_addr(input logic [4:0] col, input logic [4:0] row,
                                        output logic [6:0] mc, output logic [6:0] mr);
    int cx;
    int cy;
    int x;
    int y;
    int a;
    cx = int'(scroll_x_px >> 4) + int'(col);
    cy = int'(scroll_y_px >> 4) + int'(row);
    if (layout_wide) begin
      x = cx & 127;
      y = cy & 63;
      a = ((y & 'hF0) << 8) + 32 * (y & 'h0F);
    end else begin
      x = cx & 63;
      y = cy & 127;
      a = ((y & 'hF0) << 7) + 32 * (y & 'h0F);
    end
    a += ((x & 'hF0) << 5) + 2 * (x & 'h0F);
    mc = 7'(x);
    mr = 7'(y);
    return a % bstf_pkg::RAM_BYTES;
  endfunction

  // Apply one command to the local state and work out the reply it should produce.
  function automatic bstf_pkg::result_t tilemap_outcome(bstf_pkg::cmd_t c);
    bstf_pkg::result_t r;
    int                a;
    logic [7:0]        code;
    logic [7:0]        attr;
    logic [6:0]        mc;
    logic [6:0]        mr;
    logic [13:0]       cpu_a;
    r = '0;
    cpu_a = {cpu_page, c.cpu_offset};
    case (c.action)
      bstf_pkg::ACT_RAM_WRITE: bg_ram[cpu_a] = c.write_data;
      bstf_pkg::ACT_RAM_READ:  r.read_data = bg_ram[cpu_a];
      bstf_pkg::ACT_PAGE_SEL:  cpu_page = c.write_data[1:0];
      default: begin
        a = map_entry_addr(c.screen_col, c.screen_row, mc, mr);
        code = bg_ram[a];
        attr = bg_ram[a + 1];
        r.tile_code   = {attr[2:0], code};
        r.tile_colour = attr[6:3];
        r.tile_flip_x = attr[7];
        r.map_col     = mc;
        r.map_row     = mr;
        r.tile_valid  = layer_on;
      end
    endcase
    return r;
  endfunction

  function automatic bstf_pkg::cmd_t mk_cmd(logic [1:0] act, logic [11:0] off,
                                            logic [7:0] data, logic [4:0] col,
                                            logic [4:0] row);
    bstf_pkg::cmd_t c;
    c.action     = act;
    c.cpu_offset = off;
    c.write_data = data;
    c.screen_col = col;
    c.screen_row = row;
    return c;
  endfunction

  function automatic bstf_pkg::result_t mk_res(logic [7:0] rd, logic [10:0] code,
                                               logic [3:0] colour, logic flip,
                                               logic [6:0] mc, logic [6:0] mr, logic v);
    bstf_pkg::result_t r;
    r.read_data   = rd;
    r.tile_code   = code;
    r.tile_colour = colour;
    r.tile_flip_x = flip;
    r.map_col     = mc;
    r.map_row     = mr;
    r.tile_valid  = v;
    return r;
  endfunction

  // Mostly on the visible screen, now and then anywhere the field allows.
  function automatic logic [4:0] pick_screen_pos();
    if ($urandom_range(0, 7) == 0)
      return 5'($urandom_range(0, 31));
    return 5'($urandom_range(0, 17));
  endfunction

  // Offer one command after a random gap and hold it until the block takes it.
  task automatic issue(bstf_pkg::cmd_t c, logic lit = 1'b0, bstf_pkg::result_t lit_r = '0);
    int                gap;
    bstf_pkg::result_t r;
    r = tilemap_outcome(c);
    case (c.action)
      bstf_pkg::ACT_RAM_WRITE: n_write++;
      bstf_pkg::ACT_RAM_READ:  n_read++;
      bstf_pkg::ACT_PAGE_SEL:  n_page++;
      default:                 n_fetch++;
    endcase
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    cmd            <= c;
    staged_outcome <= lit ? lit_r : r;
    do @(posedge clk); while (busy);
  endtask

  // Let every outstanding reply arrive before anything else happens.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Registers change only with the block idle.
  task automatic configure(logic [15:0] sx, logic [15:0] sy, logic wide, logic en);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= bstf_pkg::REG_SCROLL_X;
    cfg_data  <= sx;
    @(posedge clk);
    cfg_index <= bstf_pkg::REG_SCROLL_Y;
    cfg_data  <= sy;
    @(posedge clk);
    cfg_index <= bstf_pkg::REG_WIDE_LAYOUT;
    cfg_data  <= {15'($urandom), wide};
    @(posedge clk);
    cfg_index <= bstf_pkg::REG_BG_ENABLE;
    cfg_data  <= {15'($urandom), en};
    @(posedge clk);
    cfg_we <= 1'b0;
    scroll_x_px = sx;
    scroll_y_px = sy;
    layout_wide = wide;
    layer_on    = en;
  endtask

  // Run-length guard.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL banked_scroll_tilemap_fetch");
      $finish;
    end
  end

  // Check each reply against the oldest outstanding one, then log a newly
  // accepted command transaction.
  always @(posedge clk) begin : watch_results
    bstf_pkg::result_t want;
    if (!rst && done) begin
      if (outcomes_due.size() == 0) begin
        $error("result transaction with no command outstanding");
        failures++;
      end else begin
        want = outcomes_due.pop_front();
        results_checked++;
        if (result.read_data !== want.read_data) begin
          $error("read_data: expected %0h, got %0h", want.read_data, result.read_data);
          failures++;
        end
        if (result.tile_code !== want.tile_code) begin
          $error("tile_code: expected %0h, got %0h", want.tile_code, result.tile_code);
          failures++;
        end
        if (result.tile_colour !== want.tile_colour) begin
          $error("tile_colour: expected %0h, got %0h", want.tile_colour, result.tile_colour);
          failures++;
        end
        if (result.tile_flip_x !== want.tile_flip_x) begin
          $error("tile_flip_x: expected %0b, got %0b", want.tile_flip_x, result.tile_flip_x);
          failures++;
        end
        if (result.map_col !== want.map_col) begin
          $error("map_col: expected %0d, got %0d", want.map_col, result.map_col);
          failures++;
        end
        if (result.map_row !== want.map_row) begin
          $error("map_row: expected %0d, got %0d", want.map_row, result.map_row);
          failures++;
        end
        if (result.tile_valid !== want.tile_valid) begin
          $error("tile_valid: expected %0b, got %0b", want.tile_valid, result.tile_valid);
          failures++;
        end
      end
    end
    if (!rst && start && !busy)
      outcomes_due.push_back(staged_outcome);
  end

  initial begin
    int             phase;
    int             issued;
    int             pick;
    int             a;
    bstf_pkg::cmd_t c;
    logic [4:0]     col;
    logic [4:0]     row;
    logic [6:0]     mc;
    logic [6:0]     mr;
    logic [11:0]    last_wr_off;

    last_wr_off = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table at the reset register values. Rows with lit set carry
    // the reply typed in; the rest are worked out by the predictor.
    directed = '{
      '{mk_cmd(bstf_pkg::ACT_RAM_READ,  12'h000, 8'h00, 5'd0,  5'd0),
        1'b1, mk_res(8'h00, 0, 0, 0, 0, 0, 0)},
      '{mk_cmd(bstf_pkg::ACT_RAM_READ,  12'hFFF, 8'hFF, 5'd31, 5'd31),
        1'b1, mk_res(8'h00, 0, 0, 0, 0, 0, 0)},
      '{mk_cmd(bstf_pkg::ACT_FETCH,     12'h000, 8'h00, 5'd0,  5'd0),
        1'b1, mk_res(8'h00, 0, 0, 0, 0, 0, 1)},
      '{mk_cmd(bstf_pkg::ACT_FETCH,     12'hFFF, 8'hFF, 5'd31, 5'd31),
        1'b1, mk_res(8'h00, 0, 0, 0, 31, 31, 1)},
      '{mk_cmd(bstf_pkg::ACT_FETCH,     12'h000, 8'h00, 5'd17, 5'd17),
        1'b1, mk_res(8'h00, 0, 0, 0, 17, 17, 1)},
      '{mk_cmd(bstf_pkg::ACT_RAM_WRITE, 12'h000, 8'hFF, 5'd31, 5'd31),
        1'b1, mk_res(8'h00, 0, 0, 0, 0, 0, 0)},
      '{mk_cmd(bstf_pkg::ACT_RAM_WRITE, 12'h001, 8'hFF, 5'd0,  5'd0),
        1'b1, mk_res(8'h00, 0, 0, 0, 0, 0, 0)},
      '{mk_cmd(bstf_pkg::ACT_RAM_READ,  12'h001, 8'h00, 5'd0,  5'd0),
        1'b1, mk_res(8'hFF, 0, 0, 0, 0, 0, 0)},
      '{mk_cmd(bstf_pkg::ACT_FETCH,     12'h000, 8'h00, 5'd0,  5'd0),
        1'b1, mk_res(8'h00, 11'd2047, 4'd15, 1'b1, 0, 0, 1)},
      '{mk_cmd(bstf_pkg::ACT_PAGE_SEL,  12'hFFF, 8'hFF, 5'd31, 5'd31),
        1'b1, mk_res(8'h00, 0, 0, 0, 0, 0, 0)},
      '{mk_cmd(bstf_pkg::ACT_RAM_WRITE, 12'hFFF, 8'hA5, 5'd0,  5'd0),
        1'b1, mk_res(8'h00, 0, 0, 0, 0, 0, 0)},
      '{mk_cmd(bstf_pkg::ACT_RAM_READ,  12'hFFF, 8'h00, 5'd0,  5'd0),
        1'b1, mk_res(8'hA5, 0, 0, 0, 0, 0, 0)},
      '{mk_cmd(bstf_pkg::ACT_PAGE_SEL,  12'h000, 8'hFC, 5'd0,  5'd0),
        1'b1, mk_res(8'h00, 0, 0, 0, 0, 0, 0)},
      '{mk_cmd(bstf_pkg::ACT_RAM_READ,  12'hFFF, 8'h00, 5'd0,  5'd0),
        1'b1, mk_res(8'h00, 0, 0, 0, 0, 0, 0)},
      '{mk_cmd(bstf_pkg::ACT_RAM_WRITE, 12'h002, 8'h5A, 5'd0,  5'd0),  1'b0, '0},
      '{mk_cmd(bstf_pkg::ACT_RAM_WRITE, 12'h003, 8'h81, 5'd0,  5'd0),  1'b0, '0},
      '{mk_cmd(bstf_pkg::ACT_FETCH,     12'h000, 8'h00, 5'd1,  5'd0),  1'b0, '0},
      '{mk_cmd(bstf_pkg::ACT_RAM_WRITE, 12'h220, 8'h33, 5'd0,  5'd0),  1'b0, '0},
      '{mk_cmd(bstf_pkg::ACT_RAM_WRITE, 12'h221, 8'h7E, 5'd0,  5'd0),  1'b0, '0},
      '{mk_cmd(bstf_pkg::ACT_FETCH,     12'h000, 8'h00, 5'd16, 5'd1),  1'b0, '0},
      '{mk_cmd(bstf_pkg::ACT_PAGE_SEL,  12'h000, 8'h02, 5'd0,  5'd0),  1'b0, '0},
      '{mk_cmd(bstf_pkg::ACT_RAM_WRITE, 12'h7FE, 8'h9C, 5'd0,  5'd0),  1'b0, '0},
      '{mk_cmd(bstf_pkg::ACT_RAM_READ,  12'h7FE, 8'h00, 5'd0,  5'd0),  1'b0, '0},
      '{mk_cmd(bstf_pkg::ACT_FETCH,     12'h000, 8'h00, 5'd5,  5'd6),  1'b0, '0}
    };
    foreach (directed[i])
      issue(directed[i].c, directed[i].lit, directed[i].r);

    // Random phases, each under its own register setting; the first four are
    // the corner settings, the rest drawn at random.
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: configure(16'h0000, 16'h0000, 1'b0, 1'b1);
        1: configure(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        2: configure(16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
        3: configure(16'h0000, 16'h0000, 1'b1, 1'b1);
        default: configure(16'($urandom), 16'($urandom), 1'($urandom),
                           $urandom_range(0, 3) != 0);
      endcase
      gap_max = (phase == 3 || phase == 6) ? 0 : 5;
      issued = 0;
      while (issued < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          // Plant an entry where the fetch will land, then fetch it.
          col = pick_screen_pos();
          row = pick_screen_pos();
          a = map_entry_addr(col, row, mc, mr);
          c = bstf_pkg::cmd_t'($urandom);
          c.action = bstf_pkg::ACT_PAGE_SEL;
          c.write_data[1:0] = a[13:12];
          issue(c);
          c = bstf_pkg::cmd_t'($urandom);
          c.action = bstf_pkg::ACT_RAM_WRITE;
          c.cpu_offset = a[11:0];
          issue(c);
          c = bstf_pkg::cmd_t'($urandom);
          c.action = bstf_pkg::ACT_RAM_WRITE;
          c.cpu_offset = a[11:0] | 12'h001;
          issue(c);
          c = bstf_pkg::cmd_t'($urandom);
          c.action = bstf_pkg::ACT_FETCH;
          c.screen_col = col;
          c.screen_row = row;
          issue(c);
          issued += 4;
        end else begin
          c = bstf_pkg::cmd_t'($urandom);
          if (pick < 55) begin
            c.action = bstf_pkg::ACT_FETCH;
            c.screen_col = pick_screen_pos();
            c.screen_row = pick_screen_pos();
          end else if (pick < 80) begin
            c.action = bstf_pkg::ACT_RAM_WRITE;
            last_wr_off = c.cpu_offset;
          end else if (pick < 95) begin
            c.action = bstf_pkg::ACT_RAM_READ;
            if ($urandom_range(0, 1) == 1)
              c.cpu_offset = last_wr_off;
          end else begin
            c.action = bstf_pkg::ACT_PAGE_SEL;
          end
          issue(c);
          issued++;
        end
      end
    end

    drain();
    $display("Checked %0d replies: %0d fetches, %0d reads, %0d writes, %0d page selects",
             results_checked, n_fetch, n_read, n_write, n_page);
    $display("over %0d register settings, both layouts, layer on and off, scroll extremes",
             PHASES + 1);
    if (failures == 0)
      $display("PASS banked_scroll_tilemap_fetch");
    else
      $display("FAIL banked_scroll_tilemap_fetch");
    $finish;
  end

endmodule
